@@ design/rme_pkg.sv @@
package rme_pkg;

  localparam int SAMPLE_W = 24;
  localparam int COUNT_W  = 17;
  localparam int INDEX_W  = 16;
  localparam int SUM_W    = 40;
  localparam int SQSUM_W  = 64;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int MSQ_W    = 47;
  localparam int NUM_W    = 64;
  localparam int STEP_W   = 7;
  localparam int ROOT_W   = 24;
  localparam int REM_W    = 26;
  localparam int CMP_W    = 28;

  localparam logic [COUNT_W-1:0] MAX_SAMPLES = COUNT_W'(65536);

  localparam logic [STEP_W-1:0] STEPS_MEAN = STEP_W'(SUM_W);
  localparam logic [STEP_W-1:0] STEPS_MSQ  = STEP_W'(SQSUM_W);
  localparam logic [STEP_W-1:0] STEPS_VAR  = STEP_W'(MSQ_W);
  localparam logic [STEP_W-1:0] STEPS_ROOT = STEP_W'(ROOT_W);

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } op_t;

  typedef struct packed {
    logic              start;
    op_t               op;
    logic [STEP_W-1:0] steps;
  } unit_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_MSQ_GO,
    ST_MSQ_WAIT,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_DONE
  } state_t;

endpackage

@@ design/rme_mul.sv @@
module rme_mul
  import rme_pkg::*;
(
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [SAMPLE_W-1:0] a,
  input  logic signed [SAMPLE_W-1:0] b,
  output logic signed [PROD_W-1:0]   prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign prod = prod_r;

endmodule

@@ design/rme_divsqrt.sv @@
module rme_divsqrt
  import rme_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  unit_cmd_t            cmd,
  input  logic [NUM_W-1:0]     num,
  input  logic [COUNT_W-1:0]   den,
  output logic                 done,
  output logic [NUM_W-1:0]     result
);

  // Shared shift/compare/subtract step: one quotient bit or one root bit per cycle.
  // num arrives left-aligned: the unit consumes it from its top bit down.

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  op_t                op_r, op_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [NUM_W-1:0]   quo_r, quo_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [COUNT_W-1:0] den_r, den_nxt;

  logic [CMP_W-1:0]   cmp_a, cmp_b, cmp_diff;
  logic               ge;

  always_comb begin
    unique case (op_r)
      OP_DIV: begin
        cmp_a = CMP_W'({rem_r, quo_r[NUM_W-1]});
        cmp_b = CMP_W'(den_r);
      end
      OP_SQRT: begin
        cmp_a = {rem_r, quo_r[NUM_W-1 -: 2]};
        cmp_b = CMP_W'({root_r, 2'b01});
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
    ge       = (cmp_a >= cmp_b);
    cmp_diff = cmp_a - cmp_b;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    den_nxt  = den_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      op_nxt   = cmd.op;
      cnt_nxt  = cmd.steps;
      quo_nxt  = num;
      rem_nxt  = '0;
      root_nxt = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? cmp_diff[REM_W-1:0] : cmp_a[REM_W-1:0];
      unique case (op_r)
        OP_DIV:  quo_nxt = {quo_r[NUM_W-2:0], ge};
        OP_SQRT: begin
          quo_nxt  = {quo_r[NUM_W-3:0], 2'b00};
          root_nxt = {root_r[ROOT_W-2:0], ge};
        end
        default: quo_nxt = quo_r;
      endcase
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_DIV;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    den_r  <= den_nxt;
  end

  assign done   = done_r;
  assign result = (op_r == OP_SQRT) ? NUM_W'(root_r) : quo_r;

endmodule

@@ design/running_mean_and_error_top.sv @@
// channel  | ports                                        | dir
// ---------+----------------------------------------------+-----
// input    | in_valid, in_ready, in_sample, in_last_sample | in
// result   | out_valid, out_ready, out_sample_index,       | out
//          | out_running_mean, out_mean_error,             |
//          | out_series_end, out_overflow                  |
// One request at a time; the serial divide/root unit forms the mean, mean-square
// and variance quotients and the error root, one bit per cycle. For the first
// sample of a series only the mean is formed and the error is zero.
// Synchronous active-low reset clears the count, sums and overflow flag.
// The result sits in an output register; a new request is taken while it waits,
// and the block holds at its last step until the register is free.
module running_mean_and_error_top
  import rme_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [INDEX_W-1:0]         out_sample_index,
  output logic signed [SAMPLE_W-1:0] out_running_mean,
  output logic [SAMPLE_W-1:0]        out_mean_error,
  output logic                       out_series_end,
  output logic                       out_overflow
);

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0]         count_r, count_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SQSUM_W-1:0]         sq_r, sq_nxt;
  logic                       ovf_r, ovf_nxt;

  logic signed [SAMPLE_W-1:0] smp_r, smp_nxt;
  logic                       last_r, last_nxt;
  logic signed [SAMPLE_W-1:0] mean_r, mean_nxt;
  logic [MSQ_W-1:0]           dv_r, dv_nxt;
  logic [SAMPLE_W-1:0]        err_r, err_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]         o_idx_r, o_idx_nxt;
  logic signed [SAMPLE_W-1:0] o_mean_r, o_mean_nxt;
  logic [SAMPLE_W-1:0]        o_err_r, o_err_nxt;
  logic                       o_end_r, o_end_nxt;
  logic                       o_ovf_r, o_ovf_nxt;

  unit_cmd_t                  cmd;
  logic [NUM_W-1:0]           u_num;
  logic [COUNT_W-1:0]         u_den;
  logic                       u_done;
  logic [NUM_W-1:0]           u_res;

  logic                       mul_en;
  logic signed [SAMPLE_W-1:0] mul_in;
  logic signed [PROD_W-1:0]   prod;

  logic [SUM_W-1:0]           sum_abs;
  logic [SUM_W-1:0]           q_signed;
  logic [MSQ_W-1:0]           msq;
  logic [MSQ_W-1:0]           m2;
  logic                       in_acc;

  rme_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_in),
    .b    (mul_in),
    .prod (prod)
  );

  rme_divsqrt u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .num    (u_num),
    .den    (u_den),
    .done   (u_done),
    .result (u_res)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign sum_abs  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign q_signed = sum_r[SUM_W-1] ? -u_res[SUM_W-1:0] : u_res[SUM_W-1:0];
  assign msq      = u_res[MSQ_W-1:0];
  assign m2       = prod[MSQ_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    ovf_nxt       = ovf_r;
    smp_nxt       = smp_r;
    last_nxt      = last_r;
    mean_nxt      = mean_r;
    dv_nxt        = dv_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    o_idx_nxt     = o_idx_r;
    o_mean_nxt    = o_mean_r;
    o_err_nxt     = o_err_r;
    o_end_nxt     = o_end_r;
    o_ovf_nxt     = o_ovf_r;
    cmd           = '{start: 1'b0, op: OP_DIV, steps: '0};
    u_num         = '0;
    u_den         = count_r;
    mul_en        = 1'b0;
    mul_in        = in_sample;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          smp_nxt   = in_sample;
          last_nxt  = in_last_sample;
          mul_en    = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (count_r >= MAX_SAMPLES) begin
          ovf_nxt = 1'b1;
        end else begin
          count_nxt = count_r + COUNT_W'(1);
          sum_nxt   = sum_r + SUM_W'(smp_r);
          sq_nxt    = sq_r + SQSUM_W'(prod[MSQ_W-1:0]);
        end
        state_nxt = ST_MEAN_GO;
      end
      ST_MEAN_GO: begin
        cmd       = '{start: 1'b1, op: OP_DIV, steps: STEPS_MEAN};
        u_num     = {sum_abs, (NUM_W-SUM_W)'(0)};
        state_nxt = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (u_done) begin
          mean_nxt = q_signed[SAMPLE_W-1:0];
          mul_en   = 1'b1;
          mul_in   = q_signed[SAMPLE_W-1:0];
          err_nxt  = '0;
          if (count_r == COUNT_W'(1)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_MSQ_GO;
          end
        end
      end
      ST_MSQ_GO: begin
        cmd       = '{start: 1'b1, op: OP_DIV, steps: STEPS_MSQ};
        u_num     = sq_r;
        state_nxt = ST_MSQ_WAIT;
      end
      ST_MSQ_WAIT: begin
        if (u_done) begin
          dv_nxt    = (msq > m2) ? (msq - m2) : '0;
          state_nxt = ST_VAR_GO;
        end
      end
      ST_VAR_GO: begin
        cmd       = '{start: 1'b1, op: OP_DIV, steps: STEPS_VAR};
        u_num     = {dv_r, (NUM_W-MSQ_W)'(0)};
        u_den     = count_r - COUNT_W'(1);
        state_nxt = ST_VAR_WAIT;
      end
      ST_VAR_WAIT: begin
        if (u_done) begin
          dv_nxt    = u_res[MSQ_W-1:0];
          state_nxt = ST_ROOT_GO;
        end
      end
      ST_ROOT_GO: begin
        cmd       = '{start: 1'b1, op: OP_SQRT, steps: STEPS_ROOT};
        u_num     = {1'b0, dv_r, (NUM_W-MSQ_W-1)'(0)};
        state_nxt = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (u_done) begin
          err_nxt   = u_res[SAMPLE_W-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_idx_nxt     = INDEX_W'(count_r - COUNT_W'(1));
          o_mean_nxt    = mean_r;
          o_err_nxt     = err_r;
          o_end_nxt     = last_r;
          o_ovf_nxt     = ovf_r;
          if (last_r) begin
            count_nxt = '0;
            sum_nxt   = '0;
            sq_nxt    = '0;
            ovf_nxt   = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r    <= smp_nxt;
    last_r   <= last_nxt;
    mean_r   <= mean_nxt;
    dv_r     <= dv_nxt;
    err_r    <= err_nxt;
    o_idx_r  <= o_idx_nxt;
    o_mean_r <= o_mean_nxt;
    o_err_r  <= o_err_nxt;
    o_end_r  <= o_end_nxt;
    o_ovf_r  <= o_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sample_index = o_idx_r;
  assign out_running_mean = o_mean_r;
  assign out_mean_error   = o_err_r;
  assign out_series_end   = o_end_r;
  assign out_overflow     = o_ovf_r;

endmodule
